FILE: sv/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// Used by sle_cell, sorted_list_engine_unit, sle_checker, sle_scoreboard and the testbench; depends on nothing.
package sle_pkg;

   localparam int POS_BITS    = 6;
   localparam int STATUS_BITS = 2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

   localparam logic CSR_IDX_DESCENDING = 1'b0;

   typedef struct packed {
      logic valid;
      logic is_read;
      logic shifting;
   } tok_type;

   typedef struct packed {
      logic remove;
      logic descending;
   } cell_cmd_type;

endpackage

FILE: sv/sorted_list_engine_unit.sv
// Top level of the sorted list engine: request control, count, mode register, cell chain.
// Depends on sle_pkg and sle_cell.
//
// Usage: a request is taken when start is high and busy is low; its result appears on
// the rsp_ ports for one cycle with rsp_valid and cannot be stalled. Clear, remove and
// refused requests (full list, bad position) leave busy low and the next request may
// follow at once; their result is registered and comes in the cycle after acceptance.
// An accepted insert or read sends a token down the chain of CAPACITY cells, one cell
// per cycle, and busy stays high until the token leaves the last cell; an insert reports
// its result in the cycle after acceptance, a read through the response register once
// its token has left the last cell. The count reported is always the count after the request.
module sorted_list_engine_unit #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32,
   localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [sle_pkg::POS_BITS-1:0]    req_position,
   output logic                            rsp_valid,
   output logic [sle_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [KEY_BITS-1:0]             rsp_read_key,
   output logic [CNT_BITS-1:0]             rsp_entry_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int WIDE = (CNT_BITS > sle_pkg::POS_BITS) ? CNT_BITS : sle_pkg::POS_BITS;
   localparam logic [CNT_BITS-1:0] CAP = CNT_BITS'(CAPACITY);

   logic                            accept;
   logic [WIDE-1:0]                 pos_wide;
   logic                            bad_pos;
   logic                            csr_write;

   logic [CNT_BITS-1:0]             count_ff, count_in;
   logic                            desc_ff, desc_in;
   logic                            busy_ff, busy_in;
   logic                            rm_ff, rm_in;
   logic [CNT_BITS-1:0]             pos_ff, pos_in;
   logic [CNT_BITS-1:0]             lim_ff, lim_in;
   sle_pkg::tok_type                launch_tok_ff, launch_tok_in;
   logic [KEY_BITS-1:0]             launch_key_ff, launch_key_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sle_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]             rsp_read_key_ff, rsp_read_key_in;
   logic [CNT_BITS-1:0]             rsp_count_ff, rsp_count_in;

   sle_pkg::cell_cmd_type           cmd;
   sle_pkg::tok_type                tok_w   [CAPACITY+1];
   logic [KEY_BITS-1:0]             carry_w [CAPACITY+1];
   logic [KEY_BITS-1:0]             key_w   [CAPACITY];
   logic [KEY_BITS-1:0]             next_w  [CAPACITY];

   assign accept    = start && !busy_ff;
   assign pos_wide  = WIDE'(req_position);
   assign bad_pos   = (pos_wide >= WIDE'(count_ff));
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == sle_pkg::CSR_IDX_DESCENDING);

   always_comb begin
      count_in        = count_ff;
      desc_in         = desc_ff;
      busy_in         = busy_ff;
      rm_in           = 1'b0;
      pos_in          = pos_ff;
      lim_in          = lim_ff;
      launch_tok_in   = '0;
      launch_key_in   = launch_key_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_read_key_in = rsp_read_key_ff;
      rsp_count_in    = rsp_count_ff;
      if (csr_write) begin
         desc_in = pwdata[0];
      end
      if (accept) begin
         pos_in          = pos_wide[CNT_BITS-1:0];
         lim_in          = count_ff;
         rsp_valid_in    = 1'b1;
         rsp_status_in   = sle_pkg::ST_DONE;
         rsp_read_key_in = '0;
         case (sle_pkg::op_type'(req_operation))
            sle_pkg::OP_INSERT: begin
               if (count_ff >= CAP) begin
                  rsp_status_in = sle_pkg::ST_FULL;
               end else begin
                  count_in      = count_ff + CNT_BITS'(1);
                  launch_tok_in = '{valid: 1'b1, is_read: 1'b0, shifting: 1'b0};
                  launch_key_in = req_key;
                  busy_in       = 1'b1;
               end
            end
            sle_pkg::OP_REMOVE: begin
               if (bad_pos) begin
                  rsp_status_in = sle_pkg::ST_RANGE;
               end else begin
                  count_in = count_ff - CNT_BITS'(1);
                  rm_in    = 1'b1;
               end
            end
            sle_pkg::OP_READ: begin
               if (bad_pos) begin
                  rsp_status_in = sle_pkg::ST_RANGE;
               end else begin
                  rsp_valid_in  = 1'b0;
                  launch_tok_in = '{valid: 1'b1, is_read: 1'b1, shifting: 1'b0};
                  busy_in       = 1'b1;
               end
            end
            sle_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         rsp_count_in = count_in;
      end
      if (tok_w[CAPACITY].valid) begin
         busy_in = 1'b0;
         if (tok_w[CAPACITY].is_read) begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = sle_pkg::ST_DONE;
            rsp_read_key_in = carry_w[CAPACITY];
            rsp_count_in    = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         desc_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         rm_ff         <= 1'b0;
         launch_tok_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         desc_ff       <= desc_in;
         busy_ff       <= busy_in;
         rm_ff         <= rm_in;
         launch_tok_ff <= launch_tok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff          <= pos_in;
      lim_ff          <= lim_in;
      launch_key_ff   <= launch_key_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_read_key_ff <= rsp_read_key_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign cmd.remove     = rm_ff;
   assign cmd.descending = desc_ff;
   assign tok_w[0]       = launch_tok_ff;
   assign carry_w[0]     = launch_key_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_tail
         assign next_w[i] = key_w[i];
      end else begin : g_body
         assign next_w[i] = key_w[i+1];
      end
      sle_cell #(
         .KEY_BITS (KEY_BITS),
         .CNT_BITS (CNT_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .pos        (pos_ff),
         .lim        (lim_ff),
         .tok_i      (tok_w[i]),
         .carry_i    (carry_w[i]),
         .next_key_i (next_w[i]),
         .tok_o      (tok_w[i+1]),
         .carry_o    (carry_w[i+1]),
         .key_o      (key_w[i])
      );
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_key    = rsp_read_key_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign pready          = 1'b1;
   assign prdata          = (paddr[2] == sle_pkg::CSR_IDX_DESCENDING) ? {31'd0, desc_ff} : '0;

endmodule

FILE: sv/sle_cell.sv
// One storage cell of the sorted list chain: holds one key and one token stage.
// Depends on sle_pkg for the token and command structs.
module sle_cell #(
   parameter int KEY_BITS = 32,
   parameter int CNT_BITS = 7,
   parameter int INDEX    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sle_pkg::cell_cmd_type cmd,
   input  logic [CNT_BITS-1:0]   pos,
   input  logic [CNT_BITS-1:0]   lim,
   input  sle_pkg::tok_type      tok_i,
   input  logic [KEY_BITS-1:0]   carry_i,
   input  logic [KEY_BITS-1:0]   next_key_i,
   output sle_pkg::tok_type      tok_o,
   output logic [KEY_BITS-1:0]   carry_o,
   output logic [KEY_BITS-1:0]   key_o
);

   localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] carry_ff, carry_in;
   sle_pkg::tok_type    tok_ff, tok_in;
   logic                live;
   logic                after;

   always_comb begin
      key_in   = key_ff;
      tok_in   = tok_i;
      carry_in = carry_i;
      live     = (IDX < lim);
      after    = cmd.descending ? (carry_i < key_ff) : (carry_i > key_ff);
      if (cmd.remove && (IDX >= pos)) begin
         key_in = next_key_i;
      end
      if (tok_i.valid) begin
         if (tok_i.is_read) begin
            if (IDX == pos) begin
               carry_in = key_ff;
            end
         end else if (tok_i.shifting || !live || !after) begin
            // drop the carried key here, push the held one onward
            key_in          = carry_i;
            carry_in        = key_ff;
            tok_in.shifting = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      carry_ff <= carry_in;
   end

   assign tok_o   = tok_ff;
   assign carry_o = carry_ff;
   assign key_o   = key_ff;

endmodule

FILE: sv/sle_checker.sv
// Port-level checks for sorted_list_engine_unit, attached by bind.
// Depends on sle_pkg for operation and status codes.
module sle_checker #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32,
   parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [1:0]                      req_operation,
   input logic                            rsp_valid,
   input logic [sle_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [KEY_BITS-1:0]             rsp_read_key,
   input logic [CNT_BITS-1:0]             rsp_entry_count
);

   localparam logic [CNT_BITS-1:0] CAP = CNT_BITS'(CAPACITY);

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_operation == sle_pkg::OP_CLEAR) |=>
         rsp_valid && (rsp_status == sle_pkg::ST_DONE) && (rsp_entry_count == '0))
      else $error("clear did not report an empty list");

   a_refused_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sle_pkg::ST_DONE) |-> (rsp_read_key == '0))
      else $error("refused request returned a nonzero key");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sle_pkg::ST_FULL) |-> (rsp_entry_count == CAP))
      else $error("full status with count below capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CAP))
      else $error("count above capacity");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) &&
         (($past(req_operation) == sle_pkg::OP_INSERT) ||
          ($past(req_operation) == sle_pkg::OP_READ)))
      else $error("busy raised without an insert or read request");

endmodule

bind sorted_list_engine_unit sle_checker #(
   .CAPACITY (CAPACITY),
   .KEY_BITS (KEY_BITS),
   .CNT_BITS (CNT_BITS)
) u_sle_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_read_key    (rsp_read_key),
   .rsp_entry_count (rsp_entry_count)
);

FILE: verif/sle_checker.sv
// Scoreboard for the sorted list engine: tracks the mode register and the held keys,
// predicts one reply per accepted request and compares it with the rsp_ channel.
// Depends on sle_pkg.
module sle_scoreboard #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32,
   parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [sle_pkg::POS_BITS-1:0]    req_position,
   input  logic                            rsp_valid,
   input  logic [sle_pkg::STATUS_BITS-1:0] rsp_status,
   input  logic [KEY_BITS-1:0]             rsp_read_key,
   input  logic [CNT_BITS-1:0]             rsp_entry_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   input  logic [31:0]                     prdata,
   input  logic                            pready,
   output int                              pending,
   output int                              failures
);

   localparam logic [2:0] DESC_ADDR = {sle_pkg::CSR_IDX_DESCENDING, 2'b00};

   typedef struct {
      logic [sle_pkg::STATUS_BITS-1:0] status;
      logic [KEY_BITS-1:0]             read_key;
      logic [CNT_BITS-1:0]             entry_count;
   } list_reply_type;

   logic [KEY_BITS-1:0] held_keys [CAPACITY];
   int                  held_count;
   logic                descending;
   list_reply_type      awaited_replies [$];

   function automatic bit goes_later(logic [KEY_BITS-1:0] fresh, logic [KEY_BITS-1:0] held);
      return descending ? (fresh < held) : (fresh > held);
   endfunction

   task automatic apply_list_op(input sle_pkg::op_type op, input logic [KEY_BITS-1:0] key,
                                input int pos, output list_reply_type reply);
      int slot;
      reply.status   = sle_pkg::ST_DONE;
      reply.read_key = '0;
      case (op)
         sle_pkg::OP_INSERT: begin
            if (held_count >= CAPACITY) begin
               reply.status = sle_pkg::ST_FULL;
            end else begin
               slot = 0;
               while (slot < held_count && goes_later(key, held_keys[slot]))
                  slot++;
               for (int i = held_count; i > slot; i--)
                  held_keys[i] = held_keys[i-1];
               held_keys[slot] = key;
               held_count++;
            end
         end
         sle_pkg::OP_REMOVE: begin
            if (pos >= held_count) begin
               reply.status = sle_pkg::ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < held_count; i++)
                  held_keys[i] = held_keys[i+1];
               held_count--;
            end
         end
         sle_pkg::OP_READ: begin
            if (pos >= held_count)
               reply.status = sle_pkg::ST_RANGE;
            else
               reply.read_key = held_keys[pos];
         end
         default: begin
            held_count = 0;
         end
      endcase
      reply.entry_count = CNT_BITS'(held_count);
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type fresh;
      if (reset) begin
         held_count = 0;
         descending = 1'b0;
         failures   = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               $error("reply with no request outstanding: status %0d count %0d",
                      rsp_status, rsp_entry_count);
               failures++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_read_key !== want.read_key) begin
                  $error("read_key: expected %h, actual %h", want.read_key, rsp_read_key);
                  failures++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d", want.entry_count,
                         rsp_entry_count);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            apply_list_op(sle_pkg::op_type'(req_operation), req_key, int'(req_position),
                          fresh);
            awaited_replies.push_back(fresh);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == DESC_ADDR)
                  descending = pwdata[0];
            end else if (paddr == DESC_ADDR && prdata !== {31'b0, descending}) begin
               $error("prdata: expected %h, actual %h", {31'b0, descending}, prdata);
               failures++;
            end
         end
      end
      pending = awaited_replies.size();
   end

endmodule

FILE: verif/tb_sorted_list_engine_unit.sv
// Testbench top for sorted_list_engine_unit: clock, reset, request and register stimulus,
// watchdog and verdict. Depends on sle_pkg, the block and sle_scoreboard.
module tb_sorted_list_engine_unit;

   localparam int CAPACITY       = 64;
   localparam int KEY_BITS       = 32;
   localparam int CNT_BITS       = $clog2(CAPACITY + 1);
   localparam int IDLE_LIMIT     = 1000;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 175;
   localparam logic [2:0] DESC_ADDR  = {sle_pkg::CSR_IDX_DESCENDING, 2'b00};
   localparam logic [2:0] SPARE_ADDR = {~sle_pkg::CSR_IDX_DESCENDING, 2'b00};
   localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
   localparam logic [KEY_BITS-1:0] KEY_MSB = {1'b1, {(KEY_BITS-1){1'b0}}};
   localparam logic [KEY_BITS-1:0] KEY_MID = {1'b0, {(KEY_BITS-1){1'b1}}};

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_operation;
   logic [KEY_BITS-1:0]             req_key;
   logic [sle_pkg::POS_BITS-1:0]    req_position;
   logic                            rsp_valid;
   logic [sle_pkg::STATUS_BITS-1:0] rsp_status;
   logic [KEY_BITS-1:0]             rsp_read_key;
   logic [CNT_BITS-1:0]             rsp_entry_count;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [2:0]                      paddr;
   logic [31:0]                     pwdata;
   logic [31:0]                     prdata;
   logic                            pready;
   int                              pending;
   int                              failures;
   int                              idle_cycles;

   sorted_list_engine_unit #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) dut (.*);

   sle_scoreboard #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [KEY_BITS-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return KEY_BITS'($urandom_range(0, 15));
         1: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return KEY_MAX;
               2: return KEY_MSB;
               default: return KEY_MID;
            endcase
         end
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   // hold the request until the block takes it
   task automatic issue(input sle_pkg::op_type op, input logic [KEY_BITS-1:0] key,
                        input int pos);
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_position  <= sle_pkg::POS_BITS'(pos);
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      start   <= 1'b0;
      req_key <= rand_key();
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   // write, then read back
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      sle_pkg::op_type op;
      int              pick;
      int              pos;
      bit              filling;
      bit              quiet;
      logic            mode;
      start         = 1'b0;
      req_operation = sle_pkg::OP_INSERT;
      req_key       = '0;
      req_position  = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      reset         = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      csr_write(DESC_ADDR, 32'd0);
      issue(sle_pkg::OP_READ, KEY_MAX, 0);
      issue(sle_pkg::OP_REMOVE, KEY_MAX, 63);
      issue(sle_pkg::OP_INSERT, '0, 63);
      issue(sle_pkg::OP_INSERT, KEY_MAX, 0);
      issue(sle_pkg::OP_INSERT, KEY_MSB, 21);
      issue(sle_pkg::OP_INSERT, KEY_MSB, 42);
      issue(sle_pkg::OP_INSERT, KEY_MID, 0);
      issue(sle_pkg::OP_READ, '0, 0);
      issue(sle_pkg::OP_READ, '0, 4);
      issue(sle_pkg::OP_READ, KEY_MAX, 5);
      issue(sle_pkg::OP_REMOVE, '0, 2);
      issue(sle_pkg::OP_READ, '0, 2);
      issue(sle_pkg::OP_REMOVE, '0, 63);
      issue(sle_pkg::OP_CLEAR, KEY_MAX, 63);
      issue(sle_pkg::OP_READ, '0, 0);
      settle();
      csr_write(DESC_ADDR, 32'd1);
      issue(sle_pkg::OP_INSERT, KEY_BITS'(5), 0);
      issue(sle_pkg::OP_INSERT, KEY_MAX, 0);
      issue(sle_pkg::OP_INSERT, '0, 0);
      issue(sle_pkg::OP_INSERT, KEY_BITS'(5), 0);
      issue(sle_pkg::OP_READ, '0, 0);
      issue(sle_pkg::OP_READ, '0, 3);
      issue(sle_pkg::OP_REMOVE, '0, 0);
      issue(sle_pkg::OP_CLEAR, '0, 0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         csr_write(SPARE_ADDR, $urandom);
         mode = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
         csr_write(DESC_ADDR, ($urandom & ~32'd1) | {31'b0, mode});
         filling = (p % 2 == 0);
         quiet   = (p == PHASES - 1);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (!quiet && $urandom_range(0, 4) == 0)
               pause($urandom_range(1, 13));
            pick = $urandom_range(0, 99);
            if (filling)
               op = (pick < 75) ? sle_pkg::OP_INSERT :
                    (pick < 85) ? sle_pkg::OP_REMOVE : sle_pkg::OP_READ;
            else
               op = (pick < 20) ? sle_pkg::OP_INSERT : (pick < 65) ? sle_pkg::OP_REMOVE :
                    (pick < 99) ? sle_pkg::OP_READ : sle_pkg::OP_CLEAR;
            pos = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 15);
            issue(op, rand_key(), pos);
         end
      end

      settle();
      repeat (CAPACITY + 4) @(posedge clock);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
